// ----- design/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the option parser checks
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define AST_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define AST_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/dtlv_pkg.sv -----
// ---------------------------------------------------------------------------
// dtlv_pkg
// types and constants shared by the option parser front, queue and back
// ---------------------------------------------------------------------------
package dtlv_pkg;

    // option type codes
    localparam logic [7:0] TYPE_PAD    = 8'd0;
    localparam logic [7:0] TYPE_END    = 8'hff;
    localparam logic [7:0] TYPE_VENDOR = 8'd43;
    localparam logic [7:0] TYPE_BOOT   = 8'd67;

    // captured options, entry i drives valid bit i
    localparam int KNOWN_COUNT = 6;
    localparam int ADDR_COUNT  = 5;
    localparam logic [7:0] KNOWN_TYPE [KNOWN_COUNT] =
        '{8'd53, 8'd1, 8'd3, 8'd51, 8'd54, 8'd42};

    // end status codes
    localparam logic [1:0] ST_END_OPT = 2'd0;
    localparam logic [1:0] ST_BETWEEN = 2'd1;
    localparam logic [1:0] ST_TRUNC   = 2'd2;

    // input request
    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } t_in_item;

    // result request
    typedef struct packed {
        logic [1:0]  end_status;
        logic [5:0]  valid_mask;
        logic [7:0]  msg_type;
        logic [31:0] net_mask;
        logic [31:0] gateway_addr;
        logic [31:0] lease_seconds;
        logic [31:0] server_id;
        logic [31:0] ntp_addr;
        logic        vendor_info_seen;
        logic        boot_file_seen;
    } t_result;

    // classified byte between front and back
    typedef struct packed {
        logic [7:0]             data;
        logic                   is_last;
        logic                   is_pad;
        logic                   is_end;
        logic                   is_vendor;
        logic                   is_boot;
        logic [KNOWN_COUNT-1:0] known;
        logic                   len_zero;
        logic                   len_one;
        logic                   len_four;
    } t_tok;

endpackage

// ----- design/dhcp_option_tlv_parser.sv -----
// ---------------------------------------------------------------------------
// dhcp_option_tlv_parser
// parses a DHCP option area byte by byte, one result per packet
//
//   channel  | handshake           | payload
//   ---------+---------------------+---------------------------
//   input    | push / full         | i_item  (data_byte, is_last)
//   result   | empty / pop         | o_result (captured options)
//
// one byte per cycle sustained unless a last byte waits; the front is
// combinational and writes an accepted byte straight into the byte queue,
// where the parser consumes it from the registered queue slot.
// the result shows on the result ports the cycle after the last byte is parsed.
// a last byte waits in the queue while the result register holds a result
// that is not popped in the same cycle; full rises once FIFO_DEPTH bytes wait.
// reset is synchronous, active low, and empties the queue and result register.
// ---------------------------------------------------------------------------
module dhcp_option_tlv_parser #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  dtlv_pkg::t_in_item i_item,
    output logic               empty,
    input  logic               pop,
    output dtlv_pkg::t_result  o_result
);

    logic           q_wr;
    logic           q_rd;
    logic           q_full;
    logic           q_empty;
    dtlv_pkg::t_tok wr_tok;
    dtlv_pkg::t_tok rd_tok;

    assign full = q_full;

    // byte classification
    dtlv_front u_front (
        .i_push   (push),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_q_wr   (q_wr),
        .o_tok    (wr_tok)
    );

    // queue between front and back
    dtlv_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (q_wr),
        .i_wr_tok (wr_tok),
        .i_rd_en  (q_rd),
        .o_rd_tok (rd_tok),
        .o_full   (q_full),
        .o_empty  (q_empty)
    );

    // parser and result register
    dtlv_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_tok     (rd_tok),
        .o_q_rd    (q_rd),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

endmodule

// ----- design/dtlv_front.sv -----
// ---------------------------------------------------------------------------
// dtlv_front
// accepts option bytes and tags each with its possible type and length class
// ---------------------------------------------------------------------------
module dtlv_front (
    input  logic              i_push,
    input  dtlv_pkg::t_in_item i_item,
    input  logic              i_q_full,
    output logic              o_q_wr,
    output dtlv_pkg::t_tok    o_tok
);

    // take a request whenever the queue has room
    assign o_q_wr = i_push && !i_q_full;

    // byte classification, read as type or as length later by the back
    always_comb begin
        o_tok           = '0;
        o_tok.data      = i_item.data_byte;
        o_tok.is_last   = i_item.is_last;
        o_tok.is_pad    = (i_item.data_byte == dtlv_pkg::TYPE_PAD);
        o_tok.is_end    = (i_item.data_byte == dtlv_pkg::TYPE_END);
        o_tok.is_vendor = (i_item.data_byte == dtlv_pkg::TYPE_VENDOR);
        o_tok.is_boot   = (i_item.data_byte == dtlv_pkg::TYPE_BOOT);
        o_tok.len_zero  = (i_item.data_byte == 8'd0);
        o_tok.len_one   = (i_item.data_byte == 8'd1);
        o_tok.len_four  = (i_item.data_byte == 8'd4);
        for (int i = 0; i < dtlv_pkg::KNOWN_COUNT; i++) begin
            o_tok.known[i] = (i_item.data_byte == dtlv_pkg::KNOWN_TYPE[i]);
        end
    end

endmodule

// ----- design/dtlv_fifo.sv -----
// ---------------------------------------------------------------------------
// dtlv_fifo
// short queue of classified bytes between front and back
// ---------------------------------------------------------------------------
module dtlv_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_en,
    input  dtlv_pkg::t_tok i_wr_tok,
    input  logic           i_rd_en,
    output dtlv_pkg::t_tok o_rd_tok,
    output logic           o_full,
    output logic           o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    dtlv_pkg::t_tok r_slot [DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic [AW-1:0]  n_wr_ptr;
    logic [AW-1:0]  n_rd_ptr;
    logic [CW-1:0]  n_count;

    assign o_full   = (r_count == FULL_CNT);
    assign o_empty  = (r_count == '0);
    assign o_rd_tok = r_slot[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr_en) begin
            n_wr_ptr = (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_rd_en) begin
            n_rd_ptr = (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_wr_en && !i_rd_en) begin
            n_count = r_count + 1'b1;
        end else if (!i_wr_en && i_rd_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_slot[r_wr_ptr] <= i_wr_tok;
        end
    end

endmodule

// ----- design/dtlv_back.sv -----
// ---------------------------------------------------------------------------
// dtlv_back
// option parser state machine, capture registers and result register
// ---------------------------------------------------------------------------
module dtlv_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  dtlv_pkg::t_tok    i_tok,
    output logic              o_q_rd,
    input  logic              i_pop,
    output logic              o_empty,
    output dtlv_pkg::t_result o_result
);

    typedef enum logic [3:0] {
        PH_TYPE = 4'b0001,
        PH_LEN  = 4'b0010,
        PH_BODY = 4'b0100,
        PH_DONE = 4'b1000
    } t_phase;

    t_phase      r_phase,     n_phase;
    logic [5:0]  r_cur_known, n_cur_known;
    logic        r_cur_vend,  n_cur_vend;
    logic        r_cur_boot,  n_cur_boot;
    logic [7:0]  r_left,      n_left;
    logic        r_matches,   n_matches;
    logic [31:0] r_accum,     n_accum;
    logic [5:0]  r_valid,     n_valid;
    logic [7:0]  r_msg,       n_msg;
    logic [31:0] r_addr [dtlv_pkg::ADDR_COUNT];
    logic [31:0] n_addr [dtlv_pkg::ADDR_COUNT];
    logic [1:0]  r_seen,      n_seen;

    logic              r_out_valid;
    dtlv_pkg::t_result r_out;
    dtlv_pkg::t_result n_out;

    logic out_ready;
    logic fire;
    logic finish;
    logic fin_match;

    // a last byte waits until the result register can take its result
    assign out_ready = !r_out_valid || i_pop;
    assign fire      = !i_q_empty && (!i_tok.is_last || out_ready);
    assign o_q_rd    = fire;
    assign o_empty   = !r_out_valid;
    assign o_result  = r_out;

    // parse step for the byte at the queue head
    always_comb begin
        n_phase     = r_phase;
        n_cur_known = r_cur_known;
        n_cur_vend  = r_cur_vend;
        n_cur_boot  = r_cur_boot;
        n_left      = r_left;
        n_matches   = r_matches;
        n_accum     = r_accum;
        n_valid     = r_valid;
        n_msg       = r_msg;
        n_seen      = r_seen;
        n_addr      = r_addr;
        finish      = 1'b0;
        fin_match   = 1'b0;

        unique case (r_phase)
            PH_TYPE: begin
                if (i_tok.is_end) begin
                    n_phase = PH_DONE;
                end else if (!i_tok.is_pad) begin
                    n_cur_known = i_tok.known;
                    n_cur_vend  = i_tok.is_vendor;
                    n_cur_boot  = i_tok.is_boot;
                    n_phase     = PH_LEN;
                end
            end
            PH_LEN: begin
                n_left    = i_tok.data;
                n_accum   = '0;
                n_matches = (r_cur_known[0] && i_tok.len_one)
                         || ((|r_cur_known[5:1]) && i_tok.len_four);
                if (i_tok.len_zero) begin
                    finish    = 1'b1;
                    fin_match = n_matches;
                    n_phase   = PH_TYPE;
                end else begin
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                n_accum = {r_accum[23:0], i_tok.data};
                n_left  = r_left - 8'd1;
                if (r_left == 8'd1) begin
                    finish    = 1'b1;
                    fin_match = r_matches;
                    n_phase   = PH_TYPE;
                end
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_TYPE;
            end
        endcase

        // option complete: flags, then capture when the length matched
        if (finish) begin
            n_seen = r_seen | {r_cur_boot, r_cur_vend};
            if (fin_match) begin
                n_valid = r_valid | r_cur_known;
                if (r_cur_known[0]) begin
                    n_msg = n_accum[7:0];
                end
                for (int i = 0; i < dtlv_pkg::ADDR_COUNT; i++) begin
                    if (r_cur_known[i+1]) begin
                        n_addr[i] = n_accum;
                    end
                end
            end
        end
    end

    // result built from the state after this byte
    always_comb begin
        n_out                  = '0;
        if (n_phase == PH_DONE) begin
            n_out.end_status = dtlv_pkg::ST_END_OPT;
        end else if (n_phase == PH_TYPE) begin
            n_out.end_status = dtlv_pkg::ST_BETWEEN;
        end else begin
            n_out.end_status = dtlv_pkg::ST_TRUNC;
        end
        n_out.valid_mask       = n_valid;
        n_out.msg_type         = n_msg;
        n_out.net_mask         = n_addr[0];
        n_out.gateway_addr     = n_addr[1];
        n_out.lease_seconds    = n_addr[2];
        n_out.server_id        = n_addr[3];
        n_out.ntp_addr         = n_addr[4];
        n_out.vendor_info_seen = n_seen[0];
        n_out.boot_file_seen   = n_seen[1];
    end

    // parser state, cleared after every packet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (fire && i_tok.is_last)) begin
            r_phase     <= PH_TYPE;
            r_cur_known <= '0;
            r_cur_vend  <= 1'b0;
            r_cur_boot  <= 1'b0;
            r_left      <= '0;
            r_matches   <= 1'b0;
            r_accum     <= '0;
            r_valid     <= '0;
            r_msg       <= '0;
            r_seen      <= '0;
            for (int i = 0; i < dtlv_pkg::ADDR_COUNT; i++) begin
                r_addr[i] <= '0;
            end
        end else if (fire) begin
            r_phase     <= n_phase;
            r_cur_known <= n_cur_known;
            r_cur_vend  <= n_cur_vend;
            r_cur_boot  <= n_cur_boot;
            r_left      <= n_left;
            r_matches   <= n_matches;
            r_accum     <= n_accum;
            r_valid     <= n_valid;
            r_msg       <= n_msg;
            r_seen      <= n_seen;
            r_addr      <= n_addr;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && i_tok.is_last) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && i_tok.is_last) begin
            r_out <= n_out;
        end
    end

endmodule

// ----- design/dtlv_checker.sv -----
// ---------------------------------------------------------------------------
// dtlv_checker
// port level checks on the option parser
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dtlv_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_full,
    input logic              i_empty,
    input logic              i_pop,
    input dtlv_pkg::t_result i_result
);

    logic status_ok;
    logic fields_zero;

    // end status is one of the three defined codes
    assign status_ok = (i_result.end_status == dtlv_pkg::ST_END_OPT)
                    || (i_result.end_status == dtlv_pkg::ST_BETWEEN)
                    || (i_result.end_status == dtlv_pkg::ST_TRUNC);

    // a field without its valid bit reads zero
    assign fields_zero = (i_result.valid_mask[0] || i_result.msg_type == 8'd0)
                      && (i_result.valid_mask[1] || i_result.net_mask == 32'd0)
                      && (i_result.valid_mask[2] || i_result.gateway_addr == 32'd0)
                      && (i_result.valid_mask[3] || i_result.lease_seconds == 32'd0)
                      && (i_result.valid_mask[4] || i_result.server_id == 32'd0)
                      && (i_result.valid_mask[5] || i_result.ntp_addr == 32'd0);

    // queue and result register come out of reset empty
    `AST_NEXT(a_reset_empty, i_clk, 1'b1, !i_rst_n, i_empty && !i_full)

    // a waiting result holds until popped
    `AST_NEXT(a_result_hold, i_clk, i_rst_n, !i_empty && !i_pop, !i_empty && $stable(i_result))

    // end status code check
    `AST_IMPLY(a_status_code, i_clk, i_rst_n, !i_empty, status_ok)

    // uncaptured fields read zero
    `AST_IMPLY(a_field_zero, i_clk, i_rst_n, !i_empty, fields_zero)

endmodule

bind dhcp_option_tlv_parser dtlv_checker u_dtlv_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_full   (full),
    .i_empty  (empty),
    .i_pop    (pop),
    .i_result (o_result)
);

// ----- sim/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// checks the DHCP option parser against a byte-level parse model kept here;
// a short table of hand-built packets, then random option streams, with
// random idle bursts on the input and result side
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 1950;
    localparam int CALM_AFTER  = 1750;
    localparam int TAIL_CYCLES = 20;

    // known options in package order, with their expected body lengths
    localparam logic [7:0] OPT_MSG    = dtlv_pkg::KNOWN_TYPE[0];
    localparam logic [7:0] OPT_MASK   = dtlv_pkg::KNOWN_TYPE[1];
    localparam logic [7:0] OPT_ROUTER = dtlv_pkg::KNOWN_TYPE[2];
    localparam logic [7:0] KNOWN_LEN [dtlv_pkg::KNOWN_COUNT] =
        '{8'd1, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4};

    typedef enum logic [3:0] {
        WANT_TYPE  = 4'b0001,
        WANT_LEN   = 4'b0010,
        IN_BODY    = 4'b0100,
        PARSE_DONE = 4'b1000
    } t_parse_phase;

    // directed row: byte, last flag, and an optional hand-written status
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;
        logic [1:0] status;
    } t_dir_row;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push    = 1'b0;
    logic               pop     = 1'b0;
    logic               full;
    logic               empty;
    dtlv_pkg::t_in_item i_item  = '0;
    dtlv_pkg::t_result  o_result;

    // parse state mirrored from the block
    t_parse_phase phase;
    logic [7:0]   opt_type;
    logic [7:0]   body_left;
    logic         len_ok;
    logic [31:0]  accum;
    logic [5:0]   cap_mask;
    logic [7:0]   cap_msg;
    logic [31:0]  cap_addr [dtlv_pkg::ADDR_COUNT];
    logic         vendor_seen;
    logic         boot_seen;

    dtlv_pkg::t_result  pending_results [$];
    dtlv_pkg::t_in_item packet_bytes [$];
    int         errors     = 0;
    int         sent_count = 0;
    bit         calm       = 1'b0;
    int         pop_stall  = 0;

    t_dir_row dir_tab [25] = '{
        '{dtlv_pkg::TYPE_END,    1'b1, 1'b1, dtlv_pkg::ST_END_OPT},
        '{dtlv_pkg::TYPE_PAD,    1'b1, 1'b1, dtlv_pkg::ST_BETWEEN},
        '{OPT_MSG,               1'b0, 1'b0, dtlv_pkg::ST_END_OPT},
        '{8'd1,                  1'b0, 1'b0, dtlv_pkg::ST_END_OPT},
        '{8'h05,                 1'b0, 1'b0, dtlv_pkg::ST_END_OPT},
        '{dtlv_pkg::TYPE_VENDOR, 1'b0, 1'b0, dtlv_pkg::ST_END_OPT},
        '{8'd0,                  1'b0, 1'b0, dtlv_pkg::ST_END_OPT},
        '{OPT_MASK,              1'b0, 1'b0, dtlv_pkg::ST_END_OPT},
        '{8'd4,                  1'b0, 1'b0, dtlv_pkg::ST_END_OPT},
        '{8'hff,                 1'b0, 1'b0, dtlv_pkg::ST_END_OPT},
        '{8'hff,                 1'b0, 1'b0, dtlv_pkg::ST_END_OPT},
        '{8'hff,                 1'b0, 1'b0, dtlv_pkg::ST_END_OPT},
        '{8'h00,                 1'b0, 1'b0, dtlv_pkg::ST_END_OPT},
        '{dtlv_pkg::TYPE_PAD,    1'b0, 1'b0, dtlv_pkg::ST_END_OPT},
        '{OPT_ROUTER,            1'b0, 1'b0, dtlv_pkg::ST_END_OPT},
        '{8'd2,                  1'b0, 1'b0, dtlv_pkg::ST_END_OPT},
        '{8'haa,                 1'b0, 1'b0, dtlv_pkg::ST_END_OPT},
        '{8'hbb,                 1'b0, 1'b0, dtlv_pkg::ST_END_OPT},
        '{dtlv_pkg::TYPE_END,    1'b0, 1'b0, dtlv_pkg::ST_END_OPT},
        '{8'h12,                 1'b1, 1'b0, dtlv_pkg::ST_END_OPT},
        '{dtlv_pkg::TYPE_VENDOR, 1'b0, 1'b0, dtlv_pkg::ST_END_OPT},
        '{8'd3,                  1'b0, 1'b0, dtlv_pkg::ST_END_OPT},
        '{8'h01,                 1'b1, 1'b1, dtlv_pkg::ST_TRUNC},
        '{dtlv_pkg::TYPE_BOOT,   1'b0, 1'b0, dtlv_pkg::ST_END_OPT},
        '{8'd0,                  1'b1, 1'b0, dtlv_pkg::ST_END_OPT}
    };

    dhcp_option_tlv_parser u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always #1 i_clk = ~i_clk;

    // ---------------------------------------------------------------------
    // parse model
    // ---------------------------------------------------------------------

    function automatic void clear_parse();
        phase       = WANT_TYPE;
        opt_type    = '0;
        body_left   = '0;
        len_ok      = 1'b0;
        accum       = '0;
        cap_mask    = '0;
        cap_msg     = '0;
        vendor_seen = 1'b0;
        boot_seen   = 1'b0;
        for (int i = 0; i < dtlv_pkg::ADDR_COUNT; i++) cap_addr[i] = '0;
    endfunction

    // a complete option: flag it, capture it when type and length fit
    function automatic void close_option();
        if (opt_type == dtlv_pkg::TYPE_VENDOR) vendor_seen = 1'b1;
        if (opt_type == dtlv_pkg::TYPE_BOOT) boot_seen = 1'b1;
        if (len_ok) begin
            for (int i = 0; i < dtlv_pkg::KNOWN_COUNT; i++) begin
                if (dtlv_pkg::KNOWN_TYPE[i] == opt_type) begin
                    cap_mask[i] = 1'b1;
                    if (i == 0) cap_msg = accum[7:0];
                    else cap_addr[i-1] = accum;
                    break;
                end
            end
        end
    endfunction

    // advance the parse by one byte; returns 1 with the packet result on the last byte
    function automatic bit parse_byte(input dtlv_pkg::t_in_item it,
                                      output dtlv_pkg::t_result res);
        res = '0;
        case (phase)
            WANT_TYPE: begin
                if (it.data_byte == dtlv_pkg::TYPE_END) begin
                    phase = PARSE_DONE;
                end else if (it.data_byte != dtlv_pkg::TYPE_PAD) begin
                    opt_type = it.data_byte;
                    phase    = WANT_LEN;
                end
            end
            WANT_LEN: begin
                body_left = it.data_byte;
                accum     = '0;
                len_ok    = 1'b0;
                for (int i = 0; i < dtlv_pkg::KNOWN_COUNT; i++)
                    if (dtlv_pkg::KNOWN_TYPE[i] == opt_type && KNOWN_LEN[i] == it.data_byte)
                        len_ok = 1'b1;
                if (it.data_byte == 8'd0) begin
                    close_option();
                    phase = WANT_TYPE;
                end else begin
                    phase = IN_BODY;
                end
            end
            IN_BODY: begin
                accum     = {accum[23:0], it.data_byte};
                body_left = body_left - 8'd1;
                if (body_left == 8'd0) begin
                    close_option();
                    phase = WANT_TYPE;
                end
            end
            default: ;
        endcase

        if (!it.is_last) return 1'b0;

        if (phase == PARSE_DONE) res.end_status = dtlv_pkg::ST_END_OPT;
        else if (phase == WANT_TYPE) res.end_status = dtlv_pkg::ST_BETWEEN;
        else res.end_status = dtlv_pkg::ST_TRUNC;
        res.valid_mask       = cap_mask;
        res.msg_type         = cap_msg;
        res.net_mask         = cap_addr[0];
        res.gateway_addr     = cap_addr[1];
        res.lease_seconds    = cap_addr[2];
        res.server_id        = cap_addr[3];
        res.ntp_addr         = cap_addr[4];
        res.vendor_info_seen = vendor_seen;
        res.boot_file_seen   = boot_seen;
        clear_parse();
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------------
    // request driver
    // ---------------------------------------------------------------------

    // random idle burst ahead of a request
    task automatic sender_gap();
        if (!calm && $urandom_range(0, 7) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // hold one request until it is taken, then log the expected result
    task automatic send_byte(input dtlv_pkg::t_in_item it, input bit typed,
                             input dtlv_pkg::t_result typed_res);
        dtlv_pkg::t_result res;
        push   <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sent_count++;
        if (parse_byte(it, res)) pending_results.push_back(typed ? typed_res : res);
    endtask

    // stop sending until every result is back
    task automatic drain_results();
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------------
    // random packet builder
    // ---------------------------------------------------------------------

    function automatic void add_option(input logic [7:0] code, input logic [7:0] len);
        packet_bytes.push_back('{data_byte: code, is_last: 1'b0});
        packet_bytes.push_back('{data_byte: len, is_last: 1'b0});
        for (int i = 0; i < len; i++)
            packet_bytes.push_back('{data_byte: 8'($urandom_range(0, 255)), is_last: 1'b0});
    endfunction

    function automatic void build_packet();
        int         n_opt;
        int         pick;
        int         idx;
        logic [7:0] len;
        logic [7:0] code;

        packet_bytes.delete();
        if ($urandom_range(0, 9) == 0) begin
            // noise packet
            repeat ($urandom_range(1, 24))
                packet_bytes.push_back('{data_byte: 8'($urandom_range(0, 255)), is_last: 1'b0});
        end else begin
            n_opt = $urandom_range(0, 8);
            for (int k = 0; k < n_opt; k++) begin
                pick = $urandom_range(0, 15);
                idx  = $urandom_range(0, dtlv_pkg::KNOWN_COUNT - 1);
                if (pick <= 7) begin
                    add_option(dtlv_pkg::KNOWN_TYPE[idx], KNOWN_LEN[idx]);
                end else if (pick == 8) begin
                    // known type, wrong length
                    len = 8'($urandom_range(0, 6));
                    if (len == KNOWN_LEN[idx]) len = len + 8'd1;
                    add_option(dtlv_pkg::KNOWN_TYPE[idx], len);
                end else if (pick == 9) begin
                    add_option(dtlv_pkg::TYPE_VENDOR, 8'($urandom_range(0, 6)));
                end else if (pick == 10) begin
                    add_option(dtlv_pkg::TYPE_BOOT, 8'($urandom_range(0, 6)));
                end else if (pick == 11) begin
                    packet_bytes.push_back('{data_byte: dtlv_pkg::TYPE_PAD, is_last: 1'b0});
                end else if (pick <= 14) begin
                    add_option(8'($urandom_range(1, 254)), 8'($urandom_range(0, 6)));
                end else begin
                    // long body, up to the full length range
                    add_option(8'($urandom_range(1, 254)), 8'($urandom_range(0, 255)));
                end
            end

            // how the packet ends
            case ($urandom_range(0, 3))
                0: begin
                    packet_bytes.push_back('{data_byte: dtlv_pkg::TYPE_END, is_last: 1'b0});
                    repeat ($urandom_range(1, 4))
                        packet_bytes.push_back('{data_byte: 8'($urandom_range(0, 255)),
                                                 is_last: 1'b0});
                end
                1: packet_bytes.push_back('{data_byte: dtlv_pkg::TYPE_END, is_last: 1'b0});
                2: ;
                default: begin
                    // cut inside an option
                    code = ($urandom_range(0, 1) != 0) ? dtlv_pkg::KNOWN_TYPE[idx]
                                                       : 8'($urandom_range(1, 254));
                    packet_bytes.push_back('{data_byte: code, is_last: 1'b0});
                    if ($urandom_range(0, 1) != 0) begin
                        len = 8'($urandom_range(1, 8));
                        packet_bytes.push_back('{data_byte: len, is_last: 1'b0});
                        repeat ($urandom_range(0, len - 1))
                            packet_bytes.push_back('{data_byte: 8'($urandom_range(0, 255)),
                                                     is_last: 1'b0});
                    end
                end
            endcase
        end

        if (packet_bytes.size() == 0)
            packet_bytes.push_back('{data_byte: dtlv_pkg::TYPE_PAD, is_last: 1'b0});
        packet_bytes[packet_bytes.size() - 1].is_last = 1'b1;
    endfunction

    // ---------------------------------------------------------------------
    // result checker
    // ---------------------------------------------------------------------

    task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] got);
        if (got !== exp) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        dtlv_pkg::t_result exp;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (pending_results.size() == 0) begin
                    $error("result with no request pending");
                    errors++;
                end else begin
                    exp = pending_results.pop_front();
                    check_field("end_status", 32'(exp.end_status), 32'(o_result.end_status));
                    check_field("valid_mask", 32'(exp.valid_mask), 32'(o_result.valid_mask));
                    check_field("msg_type", 32'(exp.msg_type), 32'(o_result.msg_type));
                    check_field("net_mask", exp.net_mask, o_result.net_mask);
                    check_field("gateway_addr", exp.gateway_addr, o_result.gateway_addr);
                    check_field("lease_seconds", exp.lease_seconds, o_result.lease_seconds);
                    check_field("server_id", exp.server_id, o_result.server_id);
                    check_field("ntp_addr", exp.ntp_addr, o_result.ntp_addr);
                    check_field("vendor_info_seen", 32'(exp.vendor_info_seen),
                                32'(o_result.vendor_info_seen));
                    check_field("boot_file_seen", 32'(exp.boot_file_seen),
                                32'(o_result.boot_file_seen));
                end
            end
            // result-side stall bursts
            if (pop_stall > 0) begin
                pop_stall--;
                pop <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                pop_stall = $urandom_range(1, 12) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------

    initial begin
        dtlv_pkg::t_result  typed_res;
        dtlv_pkg::t_in_item it;
        bit                 mid_drained;

        mid_drained = 1'b0;
        clear_parse();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed packets
        foreach (dir_tab[r]) begin
            sender_gap();
            it.data_byte = dir_tab[r].data;
            it.is_last   = dir_tab[r].last;
            typed_res    = '0;
            typed_res.end_status = dir_tab[r].status;
            send_byte(it, dir_tab[r].typed, typed_res);
        end
        drain_results();

        // random packets
        while (sent_count < ITEM_TARGET) begin
            build_packet();
            foreach (packet_bytes[i]) begin
                calm = (sent_count >= CALM_AFTER);
                sender_gap();
                send_byte(packet_bytes[i], 1'b0, '0);
            end
            if (!mid_drained && sent_count >= ITEM_TARGET / 2) begin
                mid_drained = 1'b1;
                drain_results();
            end
        end
        calm = 1'b1;
        push <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // run limit
    initial begin
        #1000000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/dtlv_pkg.sv
design/dtlv_front.sv
design/dtlv_fifo.sv
design/dtlv_back.sv
design/dhcp_option_tlv_parser.sv
design/dtlv_checker.sv
sim/tb.sv
